// ----- rtl/cfs_pkg.sv -----
// Shared types, codes and constants of the colour fade sequencer.
`default_nettype none
package cfs_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int ELAPSED_W         = 26;
  localparam int TIME_W            = 24;
  localparam int DT_W              = 16;
  localparam int COLOUR_W          = 32;
  localparam int CFG_IDX_W         = 3;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4,
    CMD_RESET  = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 3'd0,
    REG_DURATION = 3'd1,
    REG_AUTO_REV = 3'd2,
    REG_LOOPING  = 3'd3,
    REG_FROM     = 3'd4,
    REG_TO       = 3'd5
  } cfg_reg_e;

  localparam logic [1:0] MODE_STOPPED   = 2'd0;
  localparam logic [1:0] MODE_RUNNING   = 2'd1;
  localparam logic [1:0] MODE_PAUSED    = 2'd2;
  localparam logic [1:0] MODE_COMPLETED = 2'd3;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [DT_W-1:0] dt_ticks;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       value_applied;
    logic       active;
    logic       loop_event;
    logic       complete_event;
    logic [1:0] run_state;
  } res_item_t;

endpackage
`default_nettype wire

// ----- rtl/cfs_div.sv -----
// Restoring divider, one quotient bit per cycle, for dividend below divisor.
`default_nettype none
module cfs_div #(
  parameter int FRACTION_BITS = cfs_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [cfs_pkg::TIME_W-1:0]   dividend,
  input  wire logic [cfs_pkg::TIME_W-1:0]   divisor,
  output logic                              done,
  output logic [FRACTION_BITS-1:0]          quotient
);
  import cfs_pkg::*;

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic [TIME_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [TIME_W:0]   shifted;
  logic [TIME_W+1:0] trial;
  logic              ge;

  // shared compare-subtract step
  always_comb begin
    shifted = {rem, 1'b0};
    trial   = {1'b0, shifted} - {2'b00, divisor};
    ge      = ~trial[TIME_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      quotient <= '0;
      cnt      <= CNT_W'(FRACTION_BITS);
    end else if (busy) begin
      rem      <= ge ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
      quotient <= {quotient[FRACTION_BITS-2:0], ge};
      cnt      <= cnt - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cfs_mix.sv -----
// Channel blend: base + floor((target - base) * p / ONE), one multiplier.
`default_nettype none
module cfs_mix #(
  parameter int FRACTION_BITS = cfs_pkg::FRACTION_BITS_DEF
) (
  input  wire logic [7:0]               base,
  input  wire logic [7:0]               target,
  input  wire logic [FRACTION_BITS:0]   eff,
  output logic [7:0]                    ch
);
  import cfs_pkg::*;

  logic signed [9:0]                 diff;
  logic signed [FRACTION_BITS+1:0]   p_s;
  logic signed [FRACTION_BITS+11:0]  prod;
  logic signed [FRACTION_BITS+11:0]  sum;

  always_comb begin
    diff = $signed({2'b00, target}) - $signed({2'b00, base});
    p_s  = $signed({1'b0, eff});
    prod = diff * p_s;
    // sum is never negative, so its upper bits are the floor
    sum  = $signed({4'b0000, base, {FRACTION_BITS{1'b0}}}) + prod;
    ch   = sum[FRACTION_BITS+7:FRACTION_BITS];
  end

endmodule
`default_nettype wire

// ----- rtl/colour_fade_sequencer_top.sv -----
// Top level of the colour fade sequencer: command sequencer, state and config.
//
// Channels (valid/ready, an item moves when valid and ready are both high):
//   cmd  - one command item {cmd, dt_ticks}; cmd_ready is high only while the
//          sequencer is idle, so one item is in work at a time.
//   res  - exactly one result item per command, held in an output register.
//   cfg  - register writes {cfg_index, cfg_data}, always ready; write only
//          while no command is in work. Indexes six and seven are dropped.
// Path from command accept to result valid:
//   non-tick commands and ticks while not running go straight to done; ticks
//   in the start delay pass the check first; ticks that blend a colour run a
//   divide when progress is below one, none at full progress or zero duration.
// The divide of elapsed by duration runs through one restoring divider, one
// quotient bit per cycle; the four channels then share one multiplier, one
// channel per cycle. These two units set the item time.
// Reset clears the mode to stopped, the elapsed counter, progress, the reverse
// flag and all configuration registers. While the receiver stalls, the result
// waits in the output register; the sequencer may finish the next command and
// then holds in its last step until the output register frees up.
`default_nettype none
module colour_fade_sequencer_top #(
  parameter int FRACTION_BITS = cfs_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_ready,
  input  wire cfs_pkg::cmd_item_t                cmd_item,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output cfs_pkg::res_item_t                     res_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cfs_pkg::COLOUR_W-1:0]      cfg_data
);
  import cfs_pkg::*;

  localparam logic [FRACTION_BITS:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {1'b0, {(ELAPSED_W-1){1'b1}}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_MIX   = 7'b0010000,
    S_WRAP  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // configuration
  logic [TIME_W-1:0]   delay_ticks;
  logic [TIME_W-1:0]   duration_ticks;
  logic                auto_reverse;
  logic                looping;
  logic [COLOUR_W-1:0] from_colour;
  logic [COLOUR_W-1:0] to_colour;

  // engine state
  state_t                 state;
  logic [1:0]             mode;
  logic [ELAPSED_W-1:0]   elapsed;
  logic [FRACTION_BITS:0] progress;
  logic                   reversed_pass;

  // work registers
  logic [2:0]             cmd_cur;
  logic [DT_W-1:0]        dt_cur;
  logic [FRACTION_BITS:0] eff;
  logic [1:0]             idx;
  logic [7:0]             col [4];
  logic                   applied;
  logic                   loop_ev;
  logic                   done_ev;

  // datapath nets
  logic [ELAPSED_W:0]       sum_wide;
  logic [ELAPSED_W-1:0]     elapsed_sat;
  logic                     mirror;
  logic                     div_start;
  logic                     div_done;
  logic [FRACTION_BITS-1:0] quotient;
  logic [7:0]               mix_base;
  logic [7:0]               mix_target;
  logic [7:0]               mix_ch;
  logic                     res_load;

  assign cmd_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mirror    = auto_reverse & reversed_pass;
  assign res_load  = (state == S_DONE) && (!res_valid || res_ready);
  assign div_start = (state == S_CHECK) && !elapsed[ELAPSED_W-1]
                     && (duration_ticks != '0)
                     && ({1'b0, elapsed[TIME_W-1:0]} < {1'b0, duration_ticks})
                     && (elapsed[ELAPSED_W-2:TIME_W] == '0);

  // saturating add; dt is never negative so only the top can overflow
  always_comb begin
    sum_wide = {elapsed[ELAPSED_W-1], elapsed} + {{(ELAPSED_W+1-DT_W){1'b0}}, dt_cur};
    if (!sum_wide[ELAPSED_W] && sum_wide[ELAPSED_W-1]) begin
      elapsed_sat = ELAPSED_MAX;
    end else begin
      elapsed_sat = sum_wide[ELAPSED_W-1:0];
    end
  end

  // channel 0 is red in the top byte
  always_comb begin
    mix_base   = 8'(from_colour >> {~idx, 3'b000});
    mix_target = 8'(to_colour >> {~idx, 3'b000});
  end

  cfs_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed[TIME_W-1:0]),
    .divisor  (duration_ticks),
    .done     (div_done),
    .quotient (quotient)
  );

  cfs_mix #(.FRACTION_BITS(FRACTION_BITS)) u_mix (
    .base   (mix_base),
    .target (mix_target),
    .eff    (eff),
    .ch     (mix_ch)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks    <= '0;
      duration_ticks <= '0;
      auto_reverse   <= 1'b0;
      looping        <= 1'b0;
      from_colour    <= '0;
      to_colour      <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELAY:    delay_ticks    <= cfg_data[TIME_W-1:0];
        REG_DURATION: duration_ticks <= cfg_data[TIME_W-1:0];
        REG_AUTO_REV: auto_reverse   <= cfg_data[0];
        REG_LOOPING:  looping        <= cfg_data[0];
        REG_FROM:     from_colour    <= cfg_data;
        REG_TO:       to_colour      <= cfg_data;
        default: ;
      endcase
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= MODE_STOPPED;
      elapsed       <= '0;
      progress      <= '0;
      reversed_pass <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_cur <= cmd_item.cmd;
            dt_cur  <= cmd_item.dt_ticks;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          applied <= 1'b0;
          loop_ev <= 1'b0;
          done_ev <= 1'b0;
          for (int k = 0; k < 4; k++) begin
            col[k] <= '0;
          end
          // only a tick while running goes on to the blend
          if (cmd_cur == CMD_TICK && mode == MODE_RUNNING) begin
            state <= S_CHECK;
          end else begin
            state <= S_DONE;
          end
          case (cmd_cur)
            CMD_TICK: begin
              if (mode == MODE_RUNNING) begin
                elapsed <= elapsed_sat;
              end
            end
            CMD_START: begin
              mode          <= MODE_RUNNING;
              elapsed       <= ELAPSED_W'(0) - {2'b00, delay_ticks};
              progress      <= '0;
              reversed_pass <= 1'b0;
            end
            CMD_STOP: begin
              mode     <= MODE_STOPPED;
              elapsed  <= '0;
              progress <= '0;
            end
            CMD_PAUSE: begin
              if (mode == MODE_RUNNING) begin
                mode <= MODE_PAUSED;
              end
            end
            CMD_RESUME: begin
              if (mode == MODE_PAUSED) begin
                mode <= MODE_RUNNING;
              end
            end
            CMD_RESET: begin
              elapsed       <= ELAPSED_W'(0) - {2'b00, delay_ticks};
              progress      <= '0;
              reversed_pass <= 1'b0;
            end
            default: ;
          endcase
        end
        S_CHECK: begin
          idx <= 2'd0;
          if (elapsed[ELAPSED_W-1]) begin
            // still in the delay
            state <= S_DONE;
          end else if (div_start) begin
            state <= S_DIV;
          end else begin
            // zero duration or elapsed at or past duration: full progress
            progress <= ONE;
            eff      <= mirror ? '0 : ONE;
            state    <= S_MIX;
          end
        end
        S_DIV: begin
          if (div_done) begin
            progress <= {1'b0, quotient};
            eff      <= mirror ? ONE - {1'b0, quotient} : {1'b0, quotient};
            state    <= S_MIX;
          end
        end
        S_MIX: begin
          col[idx] <= mix_ch;
          idx      <= idx + 2'd1;
          if (idx == 2'd3) begin
            applied <= 1'b1;
            state   <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (progress == ONE) begin
            if (auto_reverse && !reversed_pass) begin
              reversed_pass <= 1'b1;
              elapsed       <= '0;
              progress      <= '0;
            end else if (looping) begin
              elapsed       <= '0;
              progress      <= '0;
              reversed_pass <= 1'b0;
              loop_ev       <= 1'b1;
            end else begin
              mode    <= MODE_COMPLETED;
              done_ev <= 1'b1;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_item.red            <= col[0];
      res_item.green          <= col[1];
      res_item.blue           <= col[2];
      res_item.alpha          <= col[3];
      res_item.value_applied  <= applied;
      res_item.active         <= (mode == MODE_RUNNING) || (mode == MODE_PAUSED);
      res_item.loop_event     <= loop_ev;
      res_item.complete_event <= done_ev;
      res_item.run_state      <= mode;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cfs_checker.sv -----
// Port-level checks of the colour fade sequencer, bound to the top level.
`default_nettype none
module cfs_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           res_valid,
  input wire logic                           res_ready,
  input wire cfs_pkg::res_item_t             res_item
);
  import cfs_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  // no colour and no event without value_applied
  a_no_colour: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.value_applied |->
      res_item.red == 8'd0 && res_item.green == 8'd0 &&
      res_item.blue == 8'd0 && res_item.alpha == 8'd0 &&
      !res_item.loop_event && !res_item.complete_event)
    else $error("colour or event on a result with no colour");

  // active follows the run state
  a_active: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_item.active ==
      (res_item.run_state == MODE_RUNNING || res_item.run_state == MODE_PAUSED))
    else $error("active disagrees with run state");

  // completion leaves the engine completed, with no loop event
  a_complete: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.complete_event |->
      res_item.run_state == MODE_COMPLETED && !res_item.loop_event)
    else $error("complete event with wrong run state");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind colour_fade_sequencer_top cfs_checker u_cfs_checker (.*);
`default_nettype wire

// ----- bench/colour_fade_sequencer_top_tb.sv -----
// Self-checking bench for the colour fade sequencer: directed and random command streams.
`default_nettype none
module colour_fade_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfs_pkg::*;

  // Fixed-point and counter geometry, taken from the package defaults.
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam longint ELAPSED_MAX = (longint'(1) << (ELAPSED_W - 1)) - 1;
  localparam longint ELAPSED_MIN = -(longint'(1) << (ELAPSED_W - 1));

  // Command and register codes the package leaves unnamed.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE7 = 3'd7;

  // Slowest item is a divide plus four channel multiplies; the quiet stretch outlasts it.
  localparam int DRAIN_CYCLES = 2 * (FRAC + 10);

  typedef logic [FRAC:0] prog_t;
  typedef logic signed [ELAPSED_W-1:0] elapsed_t;

  localparam prog_t PROG_ONE = prog_t'(1) << FRAC;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_item_t cmd_item;
  logic res_valid;
  logic res_ready;
  res_item_t res_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOUR_W-1:0] cfg_data;

  colour_fade_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the fade engine: configuration and run state.
  logic [TIME_W-1:0] cfg_delay;
  logic [TIME_W-1:0] cfg_duration;
  logic cfg_auto_rev;
  logic cfg_looping;
  logic [COLOUR_W-1:0] cfg_from;
  logic [COLOUR_W-1:0] cfg_to;
  logic [1:0] fade_mode;
  elapsed_t fade_elapsed;
  prog_t fade_progress;
  logic fade_reversed;

  // Predicted result items, oldest first.
  res_item_t pending_colours[$];

  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run (~450 items).
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] mix_channel(input logic [7:0] a, input logic [7:0] b,
                                             input prog_t p);
    longint unsigned acc;
    // from*(1-p) + to*p, then floor back to eight bits
    acc = 64'(a) * 64'(PROG_ONE - p) + 64'(b) * 64'(p);
    return 8'(acc >> FRAC);
  endfunction

  function automatic void clear_fade_state();
    cfg_delay = '0;
    cfg_duration = '0;
    cfg_auto_rev = 1'b0;
    cfg_looping = 1'b0;
    cfg_from = '0;
    cfg_to = '0;
    fade_mode = MODE_STOPPED;
    fade_elapsed = '0;
    fade_progress = '0;
    fade_reversed = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [COLOUR_W-1:0] data);
    case (idx)
      REG_DELAY:    cfg_delay = data[TIME_W-1:0];
      REG_DURATION: cfg_duration = data[TIME_W-1:0];
      REG_AUTO_REV: cfg_auto_rev = data[0];
      REG_LOOPING:  cfg_looping = data[0];
      REG_FROM:     cfg_from = data;
      REG_TO:       cfg_to = data;
      default: ;
    endcase
  endfunction

  // Advance the shadow engine by one command and return the colour item it yields.
  function automatic res_item_t predict_fade(input cmd_item_t it);
    res_item_t r;
    longint sum;
    longint q;
    prog_t eff;
    r = '0;
    case (it.cmd)
      CMD_TICK: begin
        if (fade_mode == MODE_RUNNING) begin
          sum = longint'(fade_elapsed) + longint'(it.dt_ticks);
          if (sum > ELAPSED_MAX) sum = ELAPSED_MAX;
          if (sum < ELAPSED_MIN) sum = ELAPSED_MIN;
          fade_elapsed = elapsed_t'(sum);
          // still inside the start delay: counter moves, nothing drawn
          if (sum >= 0) begin
            if (cfg_duration == '0) begin
              fade_progress = PROG_ONE;
            end else begin
              q = (sum << FRAC) / longint'(cfg_duration);
              fade_progress = (q > longint'(PROG_ONE)) ? PROG_ONE : prog_t'(q);
            end
            eff = (cfg_auto_rev && fade_reversed) ? PROG_ONE - fade_progress : fade_progress;
            r.red   = mix_channel(cfg_from[31:24], cfg_to[31:24], eff);
            r.green = mix_channel(cfg_from[23:16], cfg_to[23:16], eff);
            r.blue  = mix_channel(cfg_from[15:8], cfg_to[15:8], eff);
            r.alpha = mix_channel(cfg_from[7:0], cfg_to[7:0], eff);
            r.value_applied = 1'b1;
            if (fade_progress >= PROG_ONE) begin
              if (cfg_auto_rev && !fade_reversed) begin
                fade_reversed = 1'b1;
                fade_elapsed = '0;
                fade_progress = '0;
              end else if (cfg_looping) begin
                fade_elapsed = '0;
                fade_progress = '0;
                fade_reversed = 1'b0;
                r.loop_event = 1'b1;
              end else begin
                fade_mode = MODE_COMPLETED;
                r.complete_event = 1'b1;
              end
            end
          end
        end
      end
      CMD_START: begin
        fade_mode = MODE_RUNNING;
        fade_elapsed = elapsed_t'(-longint'(cfg_delay));
        fade_progress = '0;
        fade_reversed = 1'b0;
      end
      CMD_STOP: begin
        // reverse flag survives a stop
        fade_mode = MODE_STOPPED;
        fade_elapsed = '0;
        fade_progress = '0;
      end
      CMD_PAUSE: begin
        if (fade_mode == MODE_RUNNING) fade_mode = MODE_PAUSED;
      end
      CMD_RESUME: begin
        if (fade_mode == MODE_PAUSED) fade_mode = MODE_RUNNING;
      end
      CMD_RESET: begin
        // rewind only; mode is kept even when stopped or completed
        fade_elapsed = elapsed_t'(-longint'(cfg_delay));
        fade_progress = '0;
        fade_reversed = 1'b0;
      end
      default: ;
    endcase
    r.active = (fade_mode == MODE_RUNNING) || (fade_mode == MODE_PAUSED);
    r.run_state = fade_mode;
    return r;
  endfunction

  function automatic string fmt_colour(input res_item_t r);
    return $sformatf("rgba=%02h%02h%02h%02h applied=%0b active=%0b loop=%0b done=%0b state=%0d",
                     r.red, r.green, r.blue, r.alpha, r.value_applied, r.active,
                     r.loop_event, r.complete_event, r.run_state);
  endfunction

  // Result side: random stalls, and every accepted item checked against the oldest
  // prediction.
  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_colours.size() == 0) begin
        if (fail_count < 10) $display("unexpected result item: %s", fmt_colour(res_item));
        fail_count = fail_count + 1;
      end else begin
        want = pending_colours.pop_front();
        if (res_item.red !== want.red || res_item.green !== want.green ||
            res_item.blue !== want.blue || res_item.alpha !== want.alpha ||
            res_item.value_applied !== want.value_applied ||
            res_item.active !== want.active || res_item.loop_event !== want.loop_event ||
            res_item.complete_event !== want.complete_event ||
            res_item.run_state !== want.run_state) begin
          if (fail_count < 10) begin
            $display("mismatch: expected %s", fmt_colour(want));
            $display("          actual   %s", fmt_colour(res_item));
          end
          fail_count = fail_count + 1;
        end
      end
    end
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one command item; valid stays up between back-to-back items.
  task automatic send_cmd(input logic [2:0] code, input logic [DT_W-1:0] dt);
    cmd_item_t it;
    res_item_t expected;
    it.cmd = code;
    it.dt_ticks = dt;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item <= it;
    do @(posedge clk); while (!cmd_ready);
    expected = predict_fade(it);
    pending_colours = {pending_colours, expected};
  endtask

  // Stop sending and wait until every predicted item has come back.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOUR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  // Reprogram all six registers on an idle engine. Unused upper data bits are
  // randomized; a spare index goes last to catch aliasing onto a real register.
  task automatic set_fade(input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] duration,
                          input logic auto_rev, input logic looping,
                          input logic [COLOUR_W-1:0] from_c, input logic [COLOUR_W-1:0] to_c);
    drain_results();
    write_reg(REG_DELAY, {8'($urandom), delay});
    write_reg(REG_DURATION, {8'($urandom), duration});
    write_reg(REG_AUTO_REV, {31'($urandom), auto_rev});
    write_reg(REG_LOOPING, {31'($urandom), looping});
    write_reg(REG_FROM, from_c);
    write_reg(REG_TO, to_c);
    write_reg($urandom_range(1) ? CFG_IDX_SPARE6 : CFG_IDX_SPARE7, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Reset configuration (all zero): ticks while stopped, unused codes, commands
  // that are ignored in the wrong mode, and a zero-duration fade that completes.
  task automatic test_idle_commands();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_cmd(CMD_TICK, 16'h0000);
    send_cmd(CMD_TICK, 16'hFFFF);
    send_cmd(CMD_SPARE6, 16'($urandom));
    send_cmd(CMD_SPARE7, 16'($urandom));
    send_cmd(CMD_PAUSE, 16'h0000);
    send_cmd(CMD_RESUME, 16'h0000);
    send_cmd(CMD_STOP, 16'h0000);
    send_cmd(CMD_RESET, 16'h0000);
    send_cmd(CMD_START, 16'h0000);
    send_cmd(CMD_TICK, 16'h0001);
    send_cmd(CMD_TICK, 16'h0001);
    send_cmd(CMD_RESUME, 16'h0000);
  endtask

  // One forward fade with a delay: delay ticks, pause/resume, reset while running
  // and while completed, then stop.
  task automatic test_single_fade();
    set_fade(24'd2, 24'd8, 1'b0, 1'b0, 32'h00FF_807F, 32'hFF00_017F);
    send_cmd(CMD_START, 16'h0000);
    send_cmd(CMD_TICK, 16'h0001);
    send_cmd(CMD_TICK, 16'h0001);
    send_cmd(CMD_PAUSE, 16'h0000);
    send_cmd(CMD_TICK, 16'h0003);
    send_cmd(CMD_PAUSE, 16'h0000);
    send_cmd(CMD_RESUME, 16'h0000);
    send_cmd(CMD_TICK, 16'h0005);
    send_cmd(CMD_RESET, 16'h0000);
    send_cmd(CMD_TICK, 16'hFFFF);
    send_cmd(CMD_TICK, 16'h0002);
    send_cmd(CMD_RESET, 16'h0000);
    send_cmd(CMD_STOP, 16'h0000);
  endtask

  // Mirrored return pass, loop wrap, stop during a return pass, and a return pass
  // that continues after auto-reverse is switched off.
  task automatic test_reverse_and_loop();
    set_fade(24'd0, 24'd4, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(CMD_START, 16'h0000);
    send_cmd(CMD_TICK, 16'h0004);
    send_cmd(CMD_TICK, 16'h0001);
    send_cmd(CMD_TICK, 16'h0004);
    send_cmd(CMD_TICK, 16'h0006);
    send_cmd(CMD_STOP, 16'h0000);
    send_cmd(CMD_START, 16'h0000);
    send_cmd(CMD_TICK, 16'h0004);
    // engine now sits in its return pass; drop auto-reverse underneath it
    set_fade(24'd0, 24'd4, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_cmd(CMD_TICK, 16'h0001);
    send_cmd(CMD_TICK, 16'h0004);
  endtask

  function automatic cmd_item_t random_command(input int dt_span);
    cmd_item_t it;
    int roll;
    roll = $urandom_range(99);
    case ($urandom_range(9))
      0: it.dt_ticks = '0;
      1: it.dt_ticks = '1;
      2: it.dt_ticks = 16'($urandom);
      default: it.dt_ticks = 16'($urandom_range(dt_span));
    endcase
    // Mostly ticks; restart a finished fade and resume a paused one soon.
    if ((fade_mode == MODE_STOPPED || fade_mode == MODE_COMPLETED) && roll < 50)
      it.cmd = CMD_START;
    else if (fade_mode == MODE_PAUSED && roll < 40) it.cmd = CMD_RESUME;
    else if (roll < 82) it.cmd = CMD_TICK;
    else if (roll < 86) it.cmd = CMD_START;
    else if (roll < 89) it.cmd = CMD_STOP;
    else if (roll < 92) it.cmd = CMD_PAUSE;
    else if (roll < 95) it.cmd = CMD_RESUME;
    else if (roll < 98) it.cmd = CMD_RESET;
    else if (roll < 99) it.cmd = CMD_SPARE6;
    else it.cmd = CMD_SPARE7;
    return it;
  endfunction

  // Random fades over eight settings, cycling through the four idle profiles.
  // The first two settings hit the register extremes; the rest keep durations
  // short so that ticks reach full progress, loops and completions often.
  task automatic test_random_fades(input int total_items);
    int per_phase;
    int span;
    cmd_item_t it;
    per_phase = total_items / 8;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_fade(24'd0, 24'hFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
        1: set_fade(24'hFF_FFFF, 24'd0, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        default: set_fade(24'($urandom_range(40)),
                          ($urandom_range(4) == 0) ? 24'($urandom_range(1)) :
                                                     24'($urandom_range(300)),
                          1'($urandom), 1'($urandom), $urandom(), $urandom());
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      span = int'(cfg_duration) / 3 + 1;
      if (int'(cfg_delay) / 8 + 1 > span) span = int'(cfg_delay) / 8 + 1;
      if (span > 65535) span = 65535;
      send_cmd(CMD_START, 16'h0000);
      for (int n = 1; n < per_phase; n++) begin
        it = random_command(span);
        send_cmd(it.cmd, it.dt_ticks);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clear_fade_state();
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_commands();
    test_single_fade();
    test_reverse_and_loop();
    test_random_fades(400);

    // everything back, then a quiet stretch to catch stray result items
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/cfs_pkg.sv
rtl/cfs_div.sv
rtl/cfs_mix.sv
rtl/colour_fade_sequencer_top.sv
rtl/cfs_checker.sv
bench/colour_fade_sequencer_top_tb.sv
